// File: hdl/meb_pkg.sv
// Shared types, constants and fixed-point helpers for the Mandelbrot escape band core.
// No dependencies; imported by meb_mul and mandelbrot_escape_band_core.
package meb_pkg;

  localparam int FRAC_W      = 20;
  localparam int RECIP_SHIFT = 33;

  // ceil(2^33 / 10): exact floor division by ten for dividends below 2^30.
  localparam logic signed [31:0] RECIP10    = 32'sd858993460;
  localparam logic signed [32:0] ESC_LIMIT  = 33'sh000400000;
  localparam logic        [4:0]  ROUND_HALF = 5'd5;

  localparam logic [7:0] CAP_RESET  = 8'd128;
  localparam logic [2:0] BAND_RESET = 3'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCX,
    S_SCY,
    S_SCI,
    S_MRR,
    S_MII,
    S_MRI,
    S_UPD,
    S_FIN
  } meb_state_t;

  // Q12.20 product: floor shift by the fraction width, then clamp to 32 bits.
  function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
    logic signed [43:0] q;
    q = p[63:FRAC_W];
    if (q[43:31] == {13{q[43]}}) begin
      sat_prod = q[31:0];
    end else if (q[43]) begin
      sat_prod = {1'b1, {31{1'b0}}};
    end else begin
      sat_prod = {1'b0, {31{1'b1}}};
    end
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [33:0] s);
    if (s[33:31] == {3{s[33]}}) begin
      sat_sum = s[31:0];
    end else if (s[33]) begin
      sat_sum = {1'b1, {31{1'b0}}};
    end else begin
      sat_sum = {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

// File: hdl/meb_mul.sv
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on meb_pkg for the Q12.20 saturating product view.
module meb_mul
  import meb_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] mul_a,
  input  logic signed [31:0] mul_b,
  output logic signed [63:0] prod,
  output logic signed [31:0] prod_fx
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod    = prod_r;
  assign prod_fx = sat_prod(prod_r);

endmodule

// File: hdl/mandelbrot_escape_band_core.sv
// Mandelbrot escape-time core: one input point in, one iteration count and band flag out.
// Depends on meb_pkg and meb_mul (the shared multiplier).
//
// Usage:
//   The input channel (in_valid/in_ready) carries one point as signed Q8.8 coordinates.
//   The point is scaled by 0.2 into c and z = z*z + c is iterated from zero in Q12.20.
//   The output channel (out_valid/out_ready) returns the final count (1 .. cap + 1) and
//   a flag that is high when the count modulo 8 matches the band residue.
//   The configuration port writes iteration_cap (index 0) or band_residue (index 1) on
//   any cycle with cfg_we high; other indices are ignored. Write only while idle.
// Timing:
//   One multiplier serves every product, so each iteration steps through three products
//   and an update (S_MRR, S_MII, S_MRI, S_UPD; the final one skips the update), and scaling
//   steps through S_SCX, S_SCY and S_SCI. One point is processed at a time; in_ready is
//   high only when the sequencer is idle, including while a finished result still waits
//   in the output register.
// Reset and stalls:
//   Synchronous active-low reset returns the sequencer to idle, clears the output valid
//   and loads cap 128 and residue 3. If the receiver stalls, a finished count waits in
//   the sequencer until the output register frees up.
module mandelbrot_escape_band_core
  import meb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_point_x,
  input  logic signed [15:0]   in_point_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic        [8:0]    out_iter_count,
  output logic                 out_in_band,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic        [7:0]    cfg_wdata
);

  meb_state_t state_r, state_nxt;

  logic        [7:0]  cap_r;
  logic        [2:0]  band_r;
  logic signed [15:0] px_r, py_r;
  logic signed [31:0] cre_r, cre_nxt;
  logic signed [31:0] cim_r, cim_nxt;
  logic signed [31:0] re_r, re_nxt;
  logic signed [31:0] im_r, im_nxt;
  logic signed [31:0] rr_r, rr_nxt;
  logic signed [31:0] ii_r, ii_nxt;
  logic        [8:0]  cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic        [8:0]  out_cnt_r;
  logic               out_band_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] prod_fx;
  logic signed [31:0] vx, vy;
  logic signed [31:0] scaled;
  logic signed [32:0] mag_sum;
  logic               escaped;
  logic               cap_hit;
  logic               out_load;
  logic               accept;

  meb_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .prod    (prod),
    .prod_fx (prod_fx)
  );

  // Dividend for the scaling: |p| * 8192 + 5, later divided by ten.
  function automatic logic signed [31:0] scale_arg(input logic signed [15:0] p);
    logic [16:0] mag;
    mag = p[15] ? (17'd0 - {p[15], p}) : {1'b0, p};
    scale_arg = {2'b00, mag, 13'b0} + {27'b0, ROUND_HALF};
  endfunction

  function automatic logic signed [31:0] scale_res(input logic signed [63:0] p,
                                                   input logic neg);
    logic [31:0] r;
    r = {7'b0, p[RECIP_SHIFT+24:RECIP_SHIFT]};
    scale_res = neg ? (32'd0 - r) : r;
  endfunction

  assign vx = scale_arg(px_r);
  assign vy = scale_arg(py_r);

  assign accept   = in_valid && in_ready;
  assign mag_sum  = {rr_r[31], rr_r} + {prod_fx[31], prod_fx};
  assign escaped  = (mag_sum >= ESC_LIMIT);
  assign cap_hit  = (cnt_r >= {1'b0, cap_r});
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign scaled   = scale_res(prod, (state_r == S_SCY) ? px_r[15] : py_r[15]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCX;
      S_SCX:  state_nxt = S_SCY;
      S_SCY:  state_nxt = S_SCI;
      S_SCI:  state_nxt = S_MRR;
      S_MRR:  state_nxt = S_MII;
      S_MII:  state_nxt = S_MRI;
      S_MRI:  state_nxt = (escaped || cap_hit) ? S_FIN : S_UPD;
      S_UPD:  state_nxt = S_MRR;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Multiplier operands and datapath updates.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    cre_nxt = cre_r;
    cim_nxt = cim_r;
    re_nxt  = re_r;
    im_nxt  = im_r;
    rr_nxt  = rr_r;
    ii_nxt  = ii_r;
    cnt_nxt = cnt_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        re_nxt   = '0;
        im_nxt   = '0;
        cnt_nxt  = '0;
      end
      S_SCX: begin
        mul_a = vx;
        mul_b = RECIP10;
      end
      S_SCY: begin
        mul_a   = vy;
        mul_b   = RECIP10;
        cre_nxt = scaled;
      end
      S_SCI: cim_nxt = scaled;
      S_MRR: begin
        mul_a = re_r;
        mul_b = re_r;
      end
      S_MII: begin
        mul_a  = im_r;
        mul_b  = im_r;
        rr_nxt = prod_fx;
      end
      S_MRI: begin
        mul_a  = re_r;
        mul_b  = im_r;
        ii_nxt = prod_fx;
        if (!escaped) cnt_nxt = cnt_r + 9'd1;
      end
      S_UPD: begin
        re_nxt = sat_sum({{2{rr_r[31]}}, rr_r} - {{2{ii_r[31]}}, ii_r}
                         + {{2{cre_r[31]}}, cre_r});
        im_nxt = sat_sum({prod_fx[31], prod_fx, 1'b0} + {{2{cim_r[31]}}, cim_r});
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      band_r      <= BAND_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAP:  cap_r  <= cfg_wdata;
          CFG_BAND: band_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    cre_r <= cre_nxt;
    cim_r <= cim_nxt;
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    rr_r  <= rr_nxt;
    ii_r  <= ii_nxt;
    cnt_r <= cnt_nxt;
    if (out_load) begin
      out_cnt_r  <= cnt_r;
      out_band_r <= (cnt_r[2:0] == band_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = out_cnt_r;
  assign out_in_band    = out_band_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("core accepted a transaction while a point was in progress");

  a_iteration_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MII) |=> (state_r == S_MRI))
    else $error("product sequence broken between im*im and re*im");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iter_count != 9'd0) && (out_iter_count <= 9'd256))
    else $error("iteration count outside 1 .. 256");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid && !out_ready |=> (state_r == S_FIN))
    else $error("finished count left the sequencer while the output was stalled");
`endif

endmodule

// File: tb/sv/mandelbrot_escape_band_core_test.sv
// Self-checking testbench for mandelbrot_escape_band_core: escape counts and band flags.
// Depends on meb_pkg for register indexes, reset values and the fraction width;
// needs only the RTL.
module mandelbrot_escape_band_core_test
  import meb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 5;
  // The limit lies above the slowest correct run, in which every point runs to its cap, every
  // result is held for the longest receiver stall and every gap is at its longest.
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  // The longest single point (cap 255) plus a receiver stall.
  localparam int END_CYCLES  = 1200;
  localparam int HOLD_CYCLES = 3000;

  // Indexes that the block has no register for.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam longint Q_MAX      = 64'sh000000007FFFFFFF;
  localparam longint Q_MIN      = 64'shFFFFFFFF80000000;
  localparam longint ESCAPE_Q20 = 64'sd4 << FRAC_W;

  typedef struct packed {
    logic [8:0] count;
    logic       band;
  } escape_result_t;

  class escape_tally;
    logic [7:0]     cap;
    logic [2:0]     residue;
    escape_result_t counts_due[$];
    int             errors;
    int             checked;
    int             at_cap;
    int             reports;

    function new();
      cap     = CAP_RESET;
      residue = BAND_RESET;
      errors  = 0;
      checked = 0;
      at_cap  = 0;
      reports = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_CAP:  cap = data;
        CFG_BAND: residue = data[2:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > Q_MAX) return Q_MAX[31:0];
      if (v < Q_MIN) return Q_MIN[31:0];
      return v[31:0];
    endfunction

    // Arithmetic shift of the exact product rounds toward minus infinity.
    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> FRAC_W);
    endfunction

    // Multiply by 0.2 and move from Q8.8 to Q12.20, rounding the magnitude to nearest.
    function logic signed [31:0] to_q20(logic signed [15:0] p);
      longint mag;
      longint r;
      mag = (p < 0) ? -longint'(p) : longint'(p);
      r = (mag * 8192 + 5) / 10;
      if (p < 0) r = -r;
      return r[31:0];
    endfunction

    function int predict_count(logic signed [15:0] px, logic signed [15:0] py);
      logic signed [31:0] c_re, c_im, re, im, rr, ii, ri, nre, nim;
      int n;
      c_re = to_q20(px);
      c_im = to_q20(py);
      re = 0;
      im = 0;
      n = 0;
      while (1) begin
        rr = qmul(re, re);
        ii = qmul(im, im);
        if (longint'(rr) + longint'(ii) >= ESCAPE_Q20) break;
        if (n >= int'(cap)) begin
          n++;
          break;
        end
        n++;
        ri  = qmul(re, im);
        nre = clamp32(longint'(rr) - longint'(ii) + longint'(c_re));
        nim = clamp32(2 * longint'(ri) + longint'(c_im));
        re  = nre;
        im  = nim;
      end
      return n;
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py);
      escape_result_t r;
      int n;
      n = predict_count(px, py);
      r.count = n[8:0];
      r.band  = (n[2:0] == residue);
      if (n == int'(cap) + 1) at_cap++;
      counts_due.push_back(r);
    endfunction

    function void check_result(logic [8:0] cnt, logic band);
      escape_result_t want;
      if (counts_due.size() == 0) begin
        errors++;
        if (reports < 40) begin
          $display("%0t: result with nothing outstanding, count %0d, band %0b", $time, cnt, band);
        end
        reports++;
        return;
      end
      want = counts_due.pop_front();
      checked++;
      if (cnt !== want.count) begin
        errors++;
        if (reports < 40) begin
          $display("%0t: iter_count mismatch, expected %0d, actual %0d", $time, want.count, cnt);
        end
        reports++;
      end
      if (band !== want.band) begin
        errors++;
        if (reports < 40) begin
          $display("%0t: in_band mismatch, expected %0b, actual %0b", $time, want.band, band);
        end
        reports++;
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   in_point_x = '0;
  logic signed [15:0]   in_point_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic        [8:0]    out_iter_count;
  logic                 out_in_band;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic        [7:0]    cfg_wdata = '0;

  escape_tally tally;
  int          burst_left = 0;
  bit          hold_pending = 1'b0;
  int          holds_done = 0;

  mandelbrot_escape_band_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_iter_count (out_iter_count),
    .out_in_band    (out_in_band),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Both monitors see the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tally.note_point(in_point_x, in_point_y);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tally.check_result(out_iter_count, out_in_band);
  end

  // Receiver: runs of always ready, random readiness, sparse readiness and full stalls,
  // with one long hold-off on request.
  initial begin : receiver
    int mode;
    int len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 60);
      for (int k = 0; k < len; k++) begin
        @(posedge clk);
        if (hold_pending) begin
          hold_pending = 1'b0;
          holds_done++;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= 1'b0;
          endcase
        end
      end
    end
  end

  // Offers one point, opening a new burst with a random gap when the last one is used up.
  task automatic offer_point(input logic [15:0] px, input logic [15:0] py);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tally.pending() != 0);
  endtask

  task automatic configure(input logic [7:0] cap, input logic [2:0] res);
    logic [4:0] junk;
    logic [7:0] word;
    junk = 5'($urandom_range(0, 31));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAP;
    cfg_wdata <= cap;
    @(posedge clk);
    tally.write_reg(CFG_CAP, cap);
    // The residue register keeps only the low three bits of the word.
    word = {junk, res};
    cfg_index <= CFG_BAND;
    cfg_wdata <= word;
    @(posedge clk);
    tally.write_reg(CFG_BAND, word);
    word = 8'($urandom_range(0, 255));
    cfg_index <= CFG_SPARE_A;
    cfg_wdata <= word;
    @(posedge clk);
    tally.write_reg(CFG_SPARE_A, word);
    word = 8'($urandom_range(0, 255));
    cfg_index <= CFG_SPARE_B;
    cfg_wdata <= word;
    @(posedge clk);
    tally.write_reg(CFG_SPARE_B, word);
    cfg_we <= 1'b0;
  endtask

  // Most points fall in the window around the set, where counts vary; the rest are
  // full-range words that nearly always escape at once.
  function automatic void pick_point(output logic [15:0] px, output logic [15:0] py);
    int          vx;
    int          vy;
    logic [31:0] raw;
    if ($urandom_range(0, 9) < 7) begin
      vx = int'($urandom_range(0, 3300)) - 2600;
      vy = int'($urandom_range(0, 3400)) - 1700;
      px = vx[15:0];
      py = vy[15:0];
    end else begin
      raw = $urandom;
      px = raw[15:0];
      py = raw[31:16];
    end
  endfunction

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run exceeded %0d cycles with %0d results outstanding",
             LIMIT_CYCLES, tally.pending());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  cap_w;
    logic [2:0]  res_w;
    logic [15:0] px;
    logic [15:0] py;
    int          n_items;
    int          n_settings;

    tally = new();
    n_settings = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: cap 128, residue 3. Extremes, the origin, points on the real
    // axis where z lands exactly on the escape radius, and points that stay bounded.
    offer_point(16'h0000, 16'h0000);
    offer_point(16'h7FFF, 16'h7FFF);
    offer_point(16'h8000, 16'h8000);
    offer_point(16'h8000, 16'h7FFF);
    offer_point(16'h7FFF, 16'h8000);
    offer_point(16'h0000, 16'h7FFF);
    offer_point(16'h8000, 16'h0000);
    offer_point(16'h0001, 16'h0000);
    offer_point(16'hFFFF, 16'h0000);
    offer_point(16'h0000, 16'hFFFF);
    offer_point(-16'sd2560, 16'h0000);
    offer_point(-16'sd2561, 16'h0000);
    offer_point(-16'sd2559, 16'h0001);
    offer_point(16'sd640, 16'h0000);
    offer_point(-16'sd1920, 16'h0000);
    offer_point(-16'sd960, 16'sd128);
    offer_point(16'h0000, 16'sd1280);
    offer_point(16'sd1280, 16'h0000);
    offer_point(-16'sd2000, -16'sd700);
    offer_point(16'sd100, -16'sd800);
    offer_point(-16'sd200, 16'sd820);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin cap_w = 8'd1;   n_items = 180; end
        1: begin cap_w = 8'd255; n_items = 40;  end
        2: begin cap_w = 8'd0;   n_items = 170; end
        3: begin cap_w = 8'd12;  n_items = 180; end
        4: begin cap_w = 8'd40;  n_items = 170; end
        5: begin cap_w = 8'd3;   n_items = 180; end
        6: begin cap_w = 8'd100; n_items = 120; end
        7: begin cap_w = 8'd7;   n_items = 180; end
        8: begin cap_w = 8'd20;  n_items = 180; end
        default: begin cap_w = 8'd6; n_items = 175; end
      endcase
      if (ph == 0) res_w = 3'd0;
      else if (ph == 1) res_w = 3'd7;
      else res_w = 3'($urandom_range(0, 7));
      configure(cap_w, res_w);
      n_settings++;
      // The receiver holds off while points keep coming, so the block backs up.
      if (ph == 3) hold_pending = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 5 && i == n_items / 2) drain();
        pick_point(px, py);
        offer_point(px, py);
      end
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);

    $display("Checked %0d points over %0d register settings, caps 0 to 255, %0d at the cap;",
             tally.checked, n_settings, tally.at_cap);
    $display("bursty input, %0d long receiver hold-off(s) and drains between settings.",
             holds_done);
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tally.errors, tally.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/meb_pkg.sv
hdl/meb_mul.sv
hdl/mandelbrot_escape_band_core.sv
tb/sv/mandelbrot_escape_band_core_test.sv
